/* rtl/core/splitmix_chained_word_hash_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the chained splitmix64 word hash.
// Both macros expect the signals clk and arst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SPLITMIX_CHAINED_WORD_HASH_TOP_ASSERT_SVH
`define SPLITMIX_CHAINED_WORD_HASH_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMCWH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smcwh: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SMCWH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smcwh: next-cycle check failed");

`endif

/* rtl/core/smcwh_pkg.sv */
// ----------------------------------------------------------------------------
// smcwh_pkg
// Shared widths, mixing constants and the result type of the word hash.
// ----------------------------------------------------------------------------
`default_nettype none

package smcwh_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = 32;

	// Finalizer multipliers and xor-shift amounts.
	localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hBF58476D1CE4E5B9;
	localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h94D049BB133111EB;
	localparam int unsigned MIX_SHIFT_A = 30;
	localparam int unsigned MIX_SHIFT_B = 27;
	localparam int unsigned MIX_SHIFT_C = 31;

	// Finished hash handed from the sequencer to the output register.
	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] hash;
	} smcwh_res_t;

endpackage

`default_nettype wire

/* rtl/core/splitmix_chained_word_hash_top.sv */
// ----------------------------------------------------------------------------
// splitmix_chained_word_hash_top
// Chained splitmix64 hash over a stream of 64-bit message words.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+----------------------------
//   input   | in        | in_valid / in_ready | data_word[63:0], last_word
//   output  | out       | out_valid/out_ready | hash_value[63:0]
//
// Each word occupies the sequencer from the accept cycle through two 64-bit
// multiplies, each built from three 32 x 32 partial products on a single
// shared multiplier. A new word is taken only once the sequencer is idle.
// Reset (arst_n low, asynchronous) clears the running hash and empties the
// output register.
// A finished hash waits in the output register while the next word is taken.
// The final step of a last word stalls only if that register is full and not being drained.
//
`default_nettype none

module splitmix_chained_word_hash_top
	import smcwh_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [WORD_W-1:0] data_word,
	input  wire logic              last_word,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [WORD_W-1:0] hash_value
);

	smcwh_res_t        res;
	logic              res_ready;
	logic              out_valid_q;
	logic [WORD_W-1:0] hash_value_q;

	// The output register can take a new hash when it is empty or being drained.
	assign res_ready = !out_valid_q || out_ready;

	smcwh_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_word (data_word),
		.last_word (last_word),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output transaction register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			hash_value_q <= res.hash;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_value_q;

endmodule

`default_nettype wire

/* rtl/core/smcwh_mul32.sv */
// ----------------------------------------------------------------------------
// smcwh_mul32
// Shared 32 x 32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module smcwh_mul32
	import smcwh_pkg::*;
(
	input  wire logic                clk,
	input  wire logic [HALF_W-1:0]   op_a,
	input  wire logic [HALF_W-1:0]   op_b,
	output logic      [2*HALF_W-1:0] product
);

	logic [2*HALF_W-1:0] product_q;

	always_ff @(posedge clk) begin
		product_q <= {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};
	end

	assign product = product_q;

endmodule

`default_nettype wire

/* rtl/core/smcwh_seq.sv */
// ----------------------------------------------------------------------------
// smcwh_seq
// Sequencer and datapath: runs each word through the finalizer, building
// every 64-bit multiply from three 32-bit partial products on one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

`include "splitmix_chained_word_hash_top_assert.svh"

module smcwh_seq
	import smcwh_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [WORD_W-1:0] data_word,
	input  wire logic              last_word,
	input  wire logic              res_ready,
	output smcwh_res_t             res
);

	typedef enum logic {
		ST_IDLE,
		ST_MUL
	} state_t;

	state_t            state_q;
	logic [1:0]        phase_q;
	logic              pass_q;
	logic              last_q;
	logic [WORD_W-1:0] run_q;
	logic [WORD_W-1:0] op_q;
	logic [WORD_W-1:0] acc_q;

	logic [WORD_W-1:0] mconst;
	logic [HALF_W-1:0] mul_a;
	logic [HALF_W-1:0] mul_b;
	logic [WORD_W-1:0] product;
	logic [HALF_W-1:0] sum_hi;
	logic [WORD_W-1:0] prod_full;
	logic [WORD_W-1:0] mix_b;
	logic [WORD_W-1:0] fin;
	logic [WORD_W-1:0] start_z;
	logic              accept;
	logic              at_end;
	logic              finish;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign mconst   = pass_q ? MIX_MUL_B : MIX_MUL_A;

	// Partial product order: lo*lo, lo*hi, hi*lo. The hi*hi term falls off the top.
	always_comb begin
		case (phase_q)
			2'd0: begin
				mul_a = op_q[HALF_W-1:0];
				mul_b = mconst[HALF_W-1:0];
			end
			2'd1: begin
				mul_a = op_q[HALF_W-1:0];
				mul_b = mconst[WORD_W-1:HALF_W];
			end
			default: begin
				mul_a = op_q[WORD_W-1:HALF_W];
				mul_b = mconst[HALF_W-1:0];
			end
		endcase
	end

	smcwh_mul32 u_mul (
		.clk     (clk),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.product (product)
	);

	assign start_z   = run_q ^ data_word;
	assign sum_hi    = acc_q[WORD_W-1:HALF_W] + product[HALF_W-1:0];
	assign prod_full = {sum_hi, acc_q[HALF_W-1:0]};
	assign mix_b     = prod_full ^ (prod_full >> MIX_SHIFT_B);
	assign fin       = prod_full ^ (prod_full >> MIX_SHIFT_C);

	assign at_end = (state_q == ST_MUL) && (phase_q == 2'd3) && pass_q;
	// A last word waits at its final step until the output register can take it.
	assign finish = at_end && (!last_q || res_ready);

	assign res.valid = finish && last_q;
	assign res.hash  = fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 2'd0;
			pass_q  <= 1'b0;
			last_q  <= 1'b0;
			run_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL;
						phase_q <= 2'd0;
						pass_q  <= 1'b0;
						last_q  <= last_word;
					end
				end
				ST_MUL: begin
					if (phase_q != 2'd3) begin
						phase_q <= phase_q + 2'd1;
					end else if (!pass_q) begin
						phase_q <= 2'd0;
						pass_q  <= 1'b1;
					end else if (finish) begin
						state_q <= ST_IDLE;
						run_q   <= last_q ? '0 : fin;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= start_z ^ (start_z >> MIX_SHIFT_A);
		end else if (state_q == ST_MUL) begin
			if (phase_q == 2'd1) begin
				acc_q <= product;
			end else if (phase_q == 2'd2) begin
				acc_q[WORD_W-1:HALF_W] <= sum_hi;
			end else if (phase_q == 2'd3 && !pass_q) begin
				op_q <= mix_b;
			end
		end
	end

	`SMCWH_ASSERT_NEXT(a_accept_busy, accept, state_q == ST_MUL && phase_q == 2'd0 && !pass_q)
	`SMCWH_ASSERT_NEXT(a_second_pass, state_q == ST_MUL && phase_q == 2'd3 && !pass_q,
		state_q == ST_MUL && phase_q == 2'd0 && pass_q)
	`SMCWH_ASSERT_NEXT(a_stall_holds, at_end && last_q && !res_ready,
		state_q == ST_MUL && phase_q == 2'd3 && pass_q && $stable(run_q))
	`SMCWH_ASSERT_NEXT(a_clear_after_emit, res.valid, run_q == '0 && state_q == ST_IDLE)

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chained splitmix64 word hash. Messages of
// directed and random words go in under bursty valid timing while the hash
// output stalls on a changing pattern. Every finished hash is checked against
// a predictor that tracks the running hash itself.
// ----------------------------------------------------------------------------

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import smcwh_pkg::*;

	// Idle cycles with no transaction on either channel before the run is
	// declared hung. This lies far beyond the longest word, sender gap or
	// receiver stall of any correct run.
	localparam int unsigned HANG_LIMIT    = 2000;
	// Cycles to watch for stray hashes after the last expected one arrived.
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned WORD_TARGET   = 1650;
	localparam int unsigned REPORT_LIMIT  = 10;

	// Ways the hash receiver takes its output.
	typedef enum int unsigned {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_e;

	// Tracks the running hash of the message in flight and holds the finished
	// hashes that the block still owes, oldest first.
	class hash_scoreboard;
		logic [WORD_W-1:0] chain_hash;
		logic [WORD_W-1:0] owed_hashes[$];
		int unsigned       error_count;

		function new();
			chain_hash  = '0;
			error_count = 0;
		endfunction

		// splitmix64 finalizer, all arithmetic modulo 2^64.
		function logic [WORD_W-1:0] splitmix_finalize(logic [WORD_W-1:0] v);
			v = v ^ (v >> MIX_SHIFT_A);
			v = v * MIX_MUL_A;
			v = v ^ (v >> MIX_SHIFT_B);
			v = v * MIX_MUL_B;
			return v ^ (v >> MIX_SHIFT_C);
		endfunction

		function void note_word(logic [WORD_W-1:0] word, logic ends_msg);
			chain_hash = splitmix_finalize(chain_hash ^ word);
			if (ends_msg) begin
				owed_hashes.push_back(chain_hash);
				chain_hash = '0;
			end
		endfunction

		function void log_failure(string what, logic [WORD_W-1:0] want,
				logic [WORD_W-1:0] got);
			error_count++;
			if (error_count <= REPORT_LIMIT)
				$display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
		endfunction

		function void check_hash(logic [WORD_W-1:0] got);
			logic [WORD_W-1:0] want;
			if (owed_hashes.size() == 0) begin
				log_failure("hash with no message pending", '0, got);
				return;
			end
			want = owed_hashes.pop_front();
			if (got !== want)
				log_failure("hash_value mismatch", want, got);
		endfunction

		function int unsigned pending();
			return owed_hashes.size();
		endfunction
	endclass

	// Every input of the block holds a known value from time zero.
	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic [WORD_W-1:0] data_word  = '0;
	logic              last_word  = 1'b0;
	logic              out_ready  = 1'b0;
	logic              in_ready;
	logic              out_valid;
	logic [WORD_W-1:0] hash_value;

	hash_scoreboard    board;
	int unsigned       words_sent = 0;
	int unsigned       idle_cycles = 0;
	rx_mode_e          rx_mode = RX_ALWAYS;
	int unsigned       rx_mode_left = 0;

	splitmix_chained_word_hash_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_word  (data_word),
		.last_word  (last_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offers one word and holds it until the block takes it. The task returns
	// in the time step of the accepting edge, so the next call can keep valid
	// high with fresh payload and no bubble. The word is handed to the
	// scoreboard here, which keeps the owed count exact for the drain below.
	task automatic send_word(logic [WORD_W-1:0] word, logic ends_msg);
		in_valid  <= 1'b1;
		data_word <= word;
		last_word <= ends_msg;
		do @(posedge clk); while (!in_ready);
		board.note_word(word, ends_msg);
		words_sent++;
	endtask

	// Sender gap. A zero gap leaves valid untouched, so a burst keeps running.
	task automatic idle_for(int unsigned cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Holds the sender back until every finished hash has come out. The task
	// always waits on the clock first, so valid is never lowered and raised in one step.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// Word contents lean toward the corners: zero, all ones, a lone set bit
	// and a lone clear bit, with plain random words in half of the transactions.
	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] one_hot;
		one_hot = 64'd1 << $urandom_range(0, WORD_W - 1);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return one_hot;
			3: return ~one_hot;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// The receiver switches between always ready, a coin toss, rare accepts
	// and a slow square wave with long stalls. Each mode lasts a random
	// stretch, so stalls land on every phase of the word schedule.
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      <= rx_mode_e'($urandom_range(0, 3));
			rx_mode_left <= $urandom_range(20, 200);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		case (rx_mode)
			RX_ALWAYS:   out_ready <= 1'b1;
			RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE:   out_ready <= ($urandom_range(0, 7) == 0);
			RX_PERIODIC: out_ready <= ((rx_mode_left % 32) < 4);
			default:     out_ready <= 1'b1;
		endcase
	end

	// Output monitor and hang watchdog. Both sample at the clock edge, where
	// every bench signal still holds the value that the edge acts on.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_hash(hash_value);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, HANG_LIMIT);
				$display("tb failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned msg_len;
		int unsigned burst_left;

		board      = new();
		burst_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed messages, back to back. A single word on a fresh state
		// gives the finalizer of that word alone; zero must hash to zero.
		send_word(64'h0000_0000_0000_0000, 1'b1);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		send_word(64'h0000_0000_0000_0001, 1'b1);
		send_word(64'h8000_0000_0000_0000, 1'b1);
		send_word(64'h8000_0000_0000_0001, 1'b1);
		// Two-word message with complementary halves.
		send_word(64'h5555_5555_5555_5555, 1'b0);
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		// Non-final words only move the running hash, zero words included.
		send_word(64'h0123_4567_89AB_CDEF, 1'b0);
		send_word(64'h0000_0000_0000_0000, 1'b0);
		send_word(64'hFEDC_BA98_7654_3210, 1'b1);
		// The same word twice must not cancel out.
		send_word(64'hDEAD_BEEF_CAFE_F00D, 1'b0);
		send_word(64'hDEAD_BEEF_CAFE_F00D, 1'b1);
		// Longer message of all ones, then all zeros.
		repeat (4) send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		repeat (3) send_word(64'h0000_0000_0000_0000, 1'b0);
		send_word(64'h0000_0000_0000_0000, 1'b1);
		// A message right after a drain starts from a clean running hash.
		drain_results();
		send_word(64'h7FFF_FFFF_FFFF_FFFE, 1'b1);

		// Random messages, mostly short, now and then long. The sender works
		// in bursts with gaps between them, and sometimes runs without gaps.
		while (words_sent < WORD_TARGET) begin
			msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
				: $urandom_range(1, 8);
			for (int unsigned i = 1; i <= msg_len; i++) begin
				if (burst_left == 0) begin
					idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
					burst_left = $urandom_range(1, 24);
				end
				burst_left--;
				send_word(pick_word(), i == msg_len);
			end
			if ($urandom_range(0, 39) == 0)
				drain_results();
		end
		in_valid <= 1'b0;

		// Wait out the remaining hashes, then watch a while for strays.
		// The watchdog bounds the wait.
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (board.error_count == 0 && board.pending() == 0) begin
			$display("tb passed");
		end else begin
			if (board.pending() != 0)
				$display("%0d hash(es) never arrived", board.pending());
			$display("tb failed");
		end
		$finish;
	end

endmodule
